>>> design/sms_pkg.sv
// Package for the sliding median filter: sizes, payload structs, the
// sorter cell link struct and the sequencer state type.
// No dependencies.
package sms_pkg;

  localparam int MAX_HALF_WINDOW = 7;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int WIN_DEPTH       = 2 * MAX_HALF_WINDOW + 1;
  localparam int IDX_W           = $clog2(WIN_DEPTH);
  localparam int CNT_W           = $clog2(WIN_DEPTH + 1);
  localparam int HW_W            = 3;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    first_sample;
    logic    last_sample;
  } in_item_t;

  typedef struct packed {
    sample_t median;
    logic    last_result;
  } out_item_t;

  // Broadcast to every sorter cell: clear empties the chain, insert adds
  // value in sorted position.
  typedef struct packed {
    logic    clear;
    logic    insert;
    sample_t value;
  } insert_t;

  // What one cell shows to its right-hand neighbor.
  typedef struct packed {
    logic    valid;
    logic    gt;
    sample_t value;
  } link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

>>> design/sms_cell.sv
// One cell of the insertion sorter chain: holds one sorted sample.
// Depends on sms_pkg.
module sms_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  sms_pkg::insert_t ins,
  input  sms_pkg::link_t   left,
  output sms_pkg::link_t   self_o
);
  import sms_pkg::*;

  logic    valid_r, valid_nxt;
  sample_t value_r, value_nxt;
  logic    gt;

  // An empty cell counts as larger than anything.
  assign gt = !valid_r || (value_r > ins.value);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ins.clear) begin
      valid_nxt = 1'b0;
    end else if (ins.insert && gt) begin
      if (left.gt) begin
        valid_nxt = left.valid;
        value_nxt = left.value;
      end else begin
        valid_nxt = 1'b1;
        value_nxt = ins.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

  assign self_o.valid = valid_r;
  assign self_o.gt    = gt;
  assign self_o.value = value_r;

endmodule

>>> design/sms_sorter.sv
// Chain of sorter cells kept in ascending order, with a rank read port.
// Depends on sms_pkg and sms_cell.
module sms_sorter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sms_pkg::insert_t            ins,
  input  logic [sms_pkg::IDX_W-1:0]   rank,
  output sms_pkg::sample_t            rank_value,
  output logic                        rank_valid
);
  import sms_pkg::*;

  link_t links [WIN_DEPTH];
  link_t head;

  // Left of the first cell sits nothing that could move right.
  assign head.valid = 1'b1;
  assign head.gt    = 1'b0;
  assign head.value = '0;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      sms_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ins    (ins),
        .left   (head),
        .self_o (links[i])
      );
    end else begin : g_rest
      sms_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ins    (ins),
        .left   (links[i-1]),
        .self_o (links[i])
      );
    end
  end

  assign rank_value = links[rank].value;
  assign rank_valid = links[rank].valid;

endmodule

>>> design/sliding_median_filter_top.sv
// Sliding median filter: window of 2h+1 samples, edge replication at both
// ends of a signal, results lag the input by h samples. An accepted sample
// causes r results (r = 0 or 1 normally, up to h+1 on a last sample) and
// keeps in_ready low until all r are handed on: every result streams its
// 2h+1 window samples one per cycle into the sorter cell chain, then passes
// the middle rank to the output register once that register is free. A
// sample with no result leaves the block ready in the following cycle. The
// next sample is taken while the last result still waits in the output register.
// Depends on sms_pkg and sms_sorter.
module sliding_median_filter_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sms_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sms_pkg::out_item_t    out_data,
  input  logic                  cfg_wr_en,
  input  logic [sms_pkg::HW_W-1:0] cfg_wr_data
);
  import sms_pkg::*;

  localparam logic [HW_W-1:0] H_MAX = HW_W'(MAX_HALF_WINDOW);

  state_t          state_r, state_nxt;
  sample_t         win_r [WIN_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [HW_W-1:0]  e_r, e_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             flush_r, flush_nxt;
  logic [HW_W-1:0]  half_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [HW_W-1:0]  h;
  logic [IDX_W-1:0] h_idx, two_h;
  logic             in_xfer, out_load;
  logic [CNT_W-1:0] cnt_base, cnt_new;
  logic [IDX_W-1:0] k_new;
  logic signed [IDX_W:0] d_raw;
  logic [IDX_W-1:0] d;
  insert_t          ins;
  sample_t          med_value;
  logic             med_valid;

  assign h     = (half_r > H_MAX) ? H_MAX : half_r;
  assign h_idx = IDX_W'(h);
  assign two_h = h_idx << 1;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign cnt_base = in_data.first_sample ? '0 : cnt_r;
  assign cnt_new  = (cnt_base < CNT_W'(WIN_DEPTH)) ? cnt_base + 1'b1 : cnt_base;
  assign k_new    = IDX_W'(cnt_new - 1'b1);

  // Distance behind the newest sample, clamped to the samples of this signal.
  assign d_raw = $signed((IDX_W+1)'(e_r)) + $signed((IDX_W+1)'(h))
               - $signed({1'b0, idx_r});
  assign d = d_raw[IDX_W] ? '0 :
             ((d_raw[IDX_W-1:0] > k_r) ? k_r : d_raw[IDX_W-1:0]);

  // The chain keeps its contents while a finished median waits for the
  // output register, and empties once the median has been taken.
  assign ins.clear  = (state_r == ST_IDLE) || out_load;
  assign ins.insert = (state_r == ST_FILL);
  assign ins.value  = win_r[d];

  sms_sorter u_sorter (
    .clk        (clk),
    .rst_n      (rst_n),
    .ins        (ins),
    .rank       (h_idx),
    .rank_value (med_value),
    .rank_valid (med_valid)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_data.last_sample || (k_new >= h_idx))) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (idx_r == two_h) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = (flush_r && (e_r != '0)) ? ST_FILL : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    idx_nxt       = idx_r;
    flush_nxt     = flush_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          k_nxt     = k_new;
          idx_nxt   = '0;
          flush_nxt = in_data.last_sample;
          if (in_data.last_sample) begin
            cnt_nxt = '0;
            e_nxt   = (k_new < h_idx) ? HW_W'(k_new) : h;
          end else begin
            cnt_nxt = cnt_new;
            e_nxt   = h;
          end
        end
      end
      ST_FILL: begin
        idx_nxt = idx_r + 1'b1;
      end
      ST_DONE: begin
        if (out_load) begin
          out_data_nxt.median      = med_value;
          out_data_nxt.last_result = flush_r && (e_r == '0);
          idx_nxt = '0;
          if (flush_r && (e_r != '0)) begin
            e_nxt = e_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      e_r         <= '0;
      idx_r       <= '0;
      flush_r     <= 1'b0;
      half_r      <= HW_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      e_r         <= e_nxt;
      idx_r       <= idx_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        half_r <= cfg_wr_data;
      end
    end
    out_data_r <= out_data_nxt;
  end

  // Window shift line; entry 0 is the newest sample.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      win_r[0] <= in_data.sample;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (idx_r <= two_h))
    else $error("sorter fill ran past the window size");

  a_median_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> med_valid)
    else $error("middle rank of the sorter is empty at hand-off");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.last_sample) |=> (cnt_r == '0))
    else $error("sample count not cleared after the last sample");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WIN_DEPTH))
    else $error("sample count above the window depth");

endmodule

>>> test/sliding_median_filter_top_tb.sv
// Testbench for sliding_median_filter_top: drives sample streams cut into signals,
// predicts every running-median result and checks each output transfer in order.
// Depends on sms_pkg and the sliding_median_filter_top RTL.
module sliding_median_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sms_pkg::*;

  localparam int          RESET_CYCLES  = 12;
  localparam int          SETTLE_CYCLES = 2 * WIN_DEPTH;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam sample_t     SAMPLE_MIN    = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam sample_t     SAMPLE_MAX    = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_wr_en = 1'b0;
  logic [HW_W-1:0]   cfg_wr_data = '0;

  // Predictor state: sample history (index 0 newest), samples seen in the
  // current signal, and the half width the block is running with.
  sample_t           sample_hist [WIN_DEPTH];
  int                signal_count;
  logic [HW_W-1:0]   half_width;
  out_item_t         median_queue [$];

  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_off_cycles;
  int                mismatch_count;
  int unsigned       cycle_count = 0;

  sliding_median_filter_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Median of the window centered e samples behind the newest one. Window
  // positions outside the signal read as its first or its newest sample.
  function automatic sample_t window_median(int e, int k);
    sample_t sorted [WIN_DEPTH];
    sample_t v;
    int      hw;
    int      n;
    int      d;
    int      j;
    hw = half_width;
    n  = 2 * hw + 1;
    for (int i = 0; i < n; i++) begin
      d = e + hw - i;
      if (d < 0) d = 0;
      if (d > k) d = k;
      sorted[i] = sample_hist[d];
    end
    for (int i = 1; i < n; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[hw];
  endfunction

  function automatic void predict_sample(in_item_t it);
    out_item_t res;
    int        hw;
    int        k;
    int        top;
    hw = half_width;
    if (it.first_sample) signal_count = 0;
    for (int i = WIN_DEPTH - 1; i > 0; i--) sample_hist[i] = sample_hist[i-1];
    sample_hist[0] = it.sample;
    if (signal_count < WIN_DEPTH) signal_count++;
    k = signal_count - 1;
    if (it.last_sample) begin
      // The closing sample flushes every position that has not left yet.
      top = (k < hw) ? k : hw;
      for (int e = top; e >= 0; e--) begin
        res.median      = window_median(e, k);
        res.last_result = (e == 0);
        median_queue = {median_queue, res};
      end
      signal_count = 0;
    end else if (k >= hw) begin
      res.median      = window_median(hw, k);
      res.last_result = 1'b0;
      median_queue = {median_queue, res};
    end
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2, 3:    return sample_t'(int'($urandom_range(6)) - 3);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Valid is only lowered when a gap is taken, so back-to-back transfers
  // never see a low and a high assignment in the same step.
  task automatic send_sample(input sample_t value, input logic is_first, input logic is_last);
    in_item_t it;
    it.sample       = value;
    it.first_sample = is_first;
    it.last_sample  = is_last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_sample(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (median_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_half_width(input logic [HW_W-1:0] hw);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hw;
    @(posedge clk);
    half_width = hw;
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (median_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: median=%0d last_result=%0b",
                   out_data.median, out_data.last_result);
      end else begin
        want = median_queue.pop_front();
        if (out_data.median !== want.median || out_data.last_result !== want.last_result) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch: expected median=%0d last_result=%0b, ",
                      "got median=%0d last_result=%0b"},
                     want.median, want.last_result, out_data.median, out_data.last_result);
        end
      end
    end
  end

  task automatic test_directed_cases();
    // Reset half width of one. The opening sample carries no start flag.
    send_sample(SAMPLE_MIN, 1'b0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0, 1'b0);
    send_sample(0, 1'b0, 1'b0);
    send_sample(-1, 1'b0, 1'b1);
    // One-sample signal.
    send_sample(16'sh1234, 1'b1, 1'b1);
    // A start flag in mid-signal drops the unfinished signal.
    send_sample(5, 1'b1, 1'b0);
    send_sample(-7, 1'b0, 1'b0);
    send_sample(100, 1'b1, 1'b0);
    send_sample(-100, 1'b0, 1'b0);
    send_sample(3, 1'b0, 1'b1);
    // New signal after a closing sample without a start flag.
    send_sample(77, 1'b0, 1'b0);
    send_sample(-77, 1'b0, 1'b1);
    drain_results();
    set_half_width(3'd7);
    // Signal shorter than the half width.
    send_sample(1000, 1'b1, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0, 1'b1);
    // Half width changed while a signal is open.
    send_sample(10, 1'b1, 1'b0);
    send_sample(-20, 1'b0, 1'b0);
    send_sample(30, 1'b0, 1'b0);
    send_sample(-40, 1'b0, 1'b0);
    drain_results();
    set_half_width(3'd0);
    send_sample(50, 1'b0, 1'b0);
    send_sample(-60, 1'b0, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1, 1'b1);
    send_sample(5, 1'b1, 1'b0);
    send_sample(6, 1'b0, 1'b1);
  endtask

  // Mostly well-formed signals of random length, with the odd missing start
  // flag, restart in mid-signal or early close mixed in.
  task automatic run_signals(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0)
        len = $urandom_range(40, 16);
      else
        len = $urandom_range(2 * half_width + 4, 1);
      for (int i = 0; i < len; i++) begin
        send_sample(rand_sample(),
                    (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0),
                    (i == len - 1) ? ($urandom_range(11) != 0) : ($urandom_range(49) == 0));
      end
      sent += len;
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    for (int seg = 0; seg < 3; seg++) begin
      drain_results();
      case ($urandom_range(3))
        0:       set_half_width(3'd0);
        1:       set_half_width(3'd7);
        default: set_half_width(3'($urandom_range(7)));
      endcase
      run_signals(n_items / 3);
    end
  endtask

  // The receiver stops for a long stretch so the block backs up into its
  // input; halfway through, the sender waits for every pending result.
  task automatic test_backpressure();
    drain_results();
    set_half_width(3'd7);
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    hold_off_cycles = 400;
    for (int i = 0; i < 30; i++) begin
      if (i == 15) drain_results();
      send_sample(rand_sample(), i == 0, i == 29);
    end
  endtask

  initial begin
    for (int i = 0; i < WIN_DEPTH; i++) sample_hist[i] = '0;
    signal_count    = 0;
    half_width      = 3'd1;
    send_idle_pct   = 25;
    recv_idle_pct   = 48;
    hold_off_cycles = 0;
    mismatch_count  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_traffic(110);
    send_idle_pct = 48;
    recv_idle_pct = 25;
    test_random_traffic(110);
    test_backpressure();
    test_random_traffic(110);

    drain_results();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
